[sv/verse_line_numbering_stream_macros.svh]
// Assertion macros shared by the verse line numbering design.
`ifndef VERSE_LINE_NUMBERING_STREAM_MACROS_SVH
`define VERSE_LINE_NUMBERING_STREAM_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define VLN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vln: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define VLN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vln: next-cycle check failed");

`endif

[sv/vln_pkg.sv]
// Package with types and constants of the verse line numbering stream.
`timescale 1ns / 1ps

package vln_pkg;

  localparam int MARKER_LEN = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [3:0] DIGIT_HI   = 4'h3;

  // Marker text, padded with zero bytes up to the table size.
  localparam logic [7:0] MARKER_TAB [16] = '{
    8'h7B, 8'h63, 8'h6F, 8'h6D, 8'h6D, 8'h65, 8'h6E, 8'h74,
    8'h3A, 8'h20, 8'h56, 8'h65, 8'h72, 8'h73, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } vln_bcd_t;

  // One classified item: the byte, whether a line prefix goes before it, and the line number.
  typedef struct packed {
    logic [7:0] data;
    logic       prefix;
    vln_bcd_t   num;
  } vln_cmd_t;

endpackage

[sv/vln_if.sv]
// Valid/ready channel interfaces for the input and result streams.
`timescale 1ns / 1ps

interface vln_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface vln_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[sv/vln_front.sv]
// Front end: tracks line and marker state and classifies each input byte.
`timescale 1ns / 1ps

module vln_front import vln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  vln_in_if.sink   in_ch,
  output logic     push_valid,
  output vln_cmd_t push_cmd,
  input  logic     push_ready
);

  logic       pend_r, pend_nxt;
  logic       blk_r, blk_nxt;
  logic       lht_r, lht_nxt;
  logic       en_r, en_nxt;
  logic [3:0] pos_r, pos_nxt;
  vln_bcd_t   cnt_r, cnt_nxt;

  logic       accept;
  logic [7:0] c;
  logic       blk_a, lht_a, en_a, emit, found;
  logic [3:0] pos_a;
  logic [4:0] pos_inc;
  vln_bcd_t   cnt_a;

  assign c          = in_ch.in_byte;
  assign accept     = in_ch.valid && push_ready;
  assign in_ch.ready = push_ready;
  assign push_valid = in_ch.valid;

  always_comb begin
    // The first byte of a line settles the line-start bookkeeping.
    blk_a = pend_r ? (blk_r && lht_r) : blk_r;
    lht_a = pend_r ? 1'b0 : lht_r;
    en_a  = pend_r ? 1'b1 : en_r;
    pos_a = pend_r ? 4'd0 : pos_r;
    emit  = pend_r && blk_a;

    // Saturating decimal increment after each prefix.
    cnt_a = cnt_r;
    if (emit && !(cnt_r.hund == 4'd9 && cnt_r.tens == 4'd9 && cnt_r.ones == 4'd9)) begin
      if (cnt_r.ones != 4'd9) begin
        cnt_a.ones = cnt_r.ones + 4'd1;
      end else begin
        cnt_a.ones = 4'd0;
        if (cnt_r.tens != 4'd9) begin
          cnt_a.tens = cnt_r.tens + 4'd1;
        end else begin
          cnt_a.tens = 4'd0;
          cnt_a.hund = cnt_r.hund + 4'd1;
        end
      end
    end

    lht_nxt = lht_a || (c != CHAR_CR && c != CHAR_LF);

    en_nxt  = en_a;
    pos_nxt = pos_a;
    pos_inc = {1'b0, pos_a} + 5'd1;
    found   = 1'b0;
    if (en_a) begin
      if (c == MARKER_TAB[pos_a]) begin
        pos_nxt = pos_inc[3:0];
        found   = (pos_inc >= 5'(MARKER_LEN));
      end else begin
        en_nxt  = 1'b0;
        pos_nxt = 4'd0;
      end
    end

    blk_nxt = blk_a;
    cnt_nxt = cnt_a;
    if (found) begin
      blk_nxt = 1'b1;
      cnt_nxt = '0;
      pos_nxt = 4'd0;
    end

    pend_nxt = (c == CHAR_LF);

    push_cmd.data   = c;
    push_cmd.prefix = emit;
    push_cmd.num    = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      blk_r  <= 1'b0;
      lht_r  <= 1'b0;
      en_r   <= 1'b1;
      pos_r  <= 4'd0;
      cnt_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      blk_r  <= blk_nxt;
      lht_r  <= lht_nxt;
      en_r   <= en_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[sv/vln_queue.sv]
// Short queue of classified items between the front end and the emitter.
`timescale 1ns / 1ps

module vln_queue import vln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  vln_cmd_t push_cmd,
  output logic     head_valid,
  output vln_cmd_t head_cmd,
  input  logic     pop
);

  vln_cmd_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

[sv/vln_back.sv]
// Emitter: expands each queued item into its prefix bytes and the byte itself.
`timescale 1ns / 1ps

module vln_back import vln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  vln_cmd_t head_cmd,
  output logic     pop,
  vln_out_if.source out_ch
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       load;
  logic [2:0] skip, sel;
  logic [7:0] ch;
  logic       last;

  assign load = head_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    // Numbers under one hundred start one slot later; a plain byte goes straight to the end.
    if (head_cmd.prefix) begin
      skip = (head_cmd.num.hund == 4'd0) ? 3'd1 : 3'd0;
    end else begin
      skip = 3'd5;
    end
    sel  = step_r + skip;
    last = (sel == 3'd5);
    unique case (sel)
      3'd0: ch = {DIGIT_HI, head_cmd.num.hund};
      3'd1: ch = (head_cmd.num.hund == 4'd0 && head_cmd.num.tens == 4'd0) ?
                 CHAR_SPACE : {DIGIT_HI, head_cmd.num.tens};
      3'd2: ch = {DIGIT_HI, head_cmd.num.ones};
      3'd3: ch = CHAR_COLON;
      3'd4: ch = CHAR_SPACE;
      default: ch = head_cmd.data;
    endcase
    pop = load && last;
    if (pop) begin
      step_nxt = 3'd0;
    end else if (load) begin
      step_nxt = step_r + 3'd1;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= ch;
      out_last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

[sv/verse_line_numbering_stream.sv]
// The first result byte passes through a queue entry and then the output register.
// The input takes one byte per cycle while the queue has room; a byte that starts a numbered
// line expands into five or six output bytes, sent through the single output register.
// The input stalls only when the two-entry queue is full.
// Reset is synchronous and active low: line state clears, matching is armed,
// the verse count returns to zero and the queue and output register empty.
`timescale 1ns / 1ps
`include "verse_line_numbering_stream_macros.svh"

module verse_line_numbering_stream import vln_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vln_in_if.sink     in_chan,
  vln_out_if.source  out_chan
);

  logic     push_valid, push_ready;
  vln_cmd_t push_cmd;
  logic     head_valid, pop;
  vln_cmd_t head_cmd;

  vln_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  vln_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  vln_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_chan)
  );

  // An item leaves the queue only with its final byte, and only if one is there.
  `VLN_ASSERT_IMPL(a_pop_has_head, pop, head_valid)
  // A prefix byte that is taken is always followed by the next byte of its run.
  `VLN_ASSERT_NEXT(a_prefix_run_unbroken,
      out_chan.valid && out_chan.ready && !out_chan.last_of_run, out_chan.valid)
  // The final byte of an item is loaded only when the output register is free.
  `VLN_ASSERT_IMPL(a_pop_is_last, pop, !(out_chan.valid && !out_chan.ready))

endmodule
